[rtl/core/bfk_pkg.sv]
// shared types and constants for the key1 blowfish block cipher
// no dependencies; imported by every module of the block
package bfk_pkg;

  localparam int ROUNDS_DEF = 16;

  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 11;
  localparam int MODE_W      = 2;
  localparam int SBOX_WORDS  = 1024;
  localparam int BANK_DEPTH  = 512;
  localparam int BANK_AW     = 9;
  localparam int S_TDATA_W   = 112;
  localparam int M_TDATA_W   = 64;

  // bit positions of the input fields inside s_axis_tdata
  localparam int TD_IDX_LSB  = 0;
  localparam int TD_WORD_LSB = TD_IDX_LSB + IDX_W;
  localparam int TD_LO_LSB   = TD_WORD_LSB + WORD_W;
  localparam int TD_HI_LSB   = TD_LO_LSB + WORD_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_ENC   = 2'd1,
    MODE_DEC   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RND_A,
    ST_RND_B,
    ST_WHT_LO,
    ST_WHT_HI
  } state_t;

  typedef struct packed {
    logic load;    // block accepted, load halves
    logic rnd_a;   // key xor, sbox lookup issued
    logic rnd_b;   // sbox data back, combine
    logic wht_lo;  // final whitening of the low half
    logic wht_hi;  // final whitening of the high half, result registered
  } dp_ctrl_t;

endpackage

[rtl/core/key1_blowfish_block_cipher.sv]
// sequence: a block transfer starts 16 rounds, each a key xor plus sbox read state then a
// combine state, followed by the low and the high whitening states
// flow: one block at a time; the input opens again only when the sequencer is back in idle,
// where it takes the next transfer; a result the sink holds off stalls the last state
// reset: rst clears the sequencer and the result valid; key table and sboxes hold
// whatever they held and must be written before use
module key1_blowfish_block_cipher
  import bfk_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // table_index[10:0], table_word[42:11], block_lo[74:43], block_hi[106:75], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_lo[31:0], out_hi[63:32]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int KEY_IDX_W = $clog2(ROUNDS + 2);

  dp_ctrl_t             ctrl;
  logic [KEY_IDX_W-1:0] key_idx;
  logic                 wr_en;
  logic [WORD_W-1:0]    out_lo;
  logic [WORD_W-1:0]    out_hi;

  assign wr_en = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_WRITE);

  bfk_ctrl #(
    .ROUNDS (ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .key_idx   (key_idx),
    .ctrl      (ctrl)
  );

  bfk_datapath #(
    .ROUNDS (ROUNDS)
  ) u_datapath (
    .clk      (clk),
    .ctrl     (ctrl),
    .key_idx  (key_idx),
    .wr_en    (wr_en),
    .wr_index (s_axis_tdata[TD_IDX_LSB +: IDX_W]),
    .wr_word  (s_axis_tdata[TD_WORD_LSB +: WORD_W]),
    .block_lo (s_axis_tdata[TD_LO_LSB +: WORD_W]),
    .block_hi (s_axis_tdata[TD_HI_LSB +: WORD_W]),
    .out_lo   (out_lo),
    .out_hi   (out_hi)
  );

  assign m_axis_tdata = {out_hi, out_lo};

endmodule

[rtl/core/bfk_sbox_ram.sv]
// one bank of the substitution store: 512 words, one write port, two read ports
// read data registered; uses bfk_pkg
module bfk_sbox_ram
  import bfk_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [BANK_AW-1:0] waddr,
  input  logic [WORD_W-1:0]  wdata,
  input  logic [BANK_AW-1:0] raddr0,
  input  logic [BANK_AW-1:0] raddr1,
  output logic [WORD_W-1:0]  rdata0,
  output logic [WORD_W-1:0]  rdata1
);

  logic [WORD_W-1:0] mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[rtl/core/bfk_ctrl.sv]
// round sequencer and output handshake for the cipher
// uses bfk_pkg; drives bfk_datapath through a dp_ctrl_t bundle
module bfk_ctrl
  import bfk_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF,
  localparam int KEY_IDX_W = $clog2(ROUNDS + 2)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    in_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KEY_IDX_W-1:0] key_idx,
  output dp_ctrl_t             ctrl
);

  localparam int RND_W = $clog2(ROUNDS);

  state_t           state;
  state_t           state_next;
  logic [RND_W-1:0] rnd;
  logic             dec;
  logic             start;
  logic             finish;

  assign start  = (state == ST_IDLE) && in_valid &&
                  ((in_mode == MODE_ENC) || (in_mode == MODE_DEC));
  assign finish = (state == ST_WHT_HI) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_RND_A;
      end
      ST_RND_A: state_next = ST_RND_B;
      ST_RND_B: begin
        if (rnd == RND_W'(ROUNDS - 1)) state_next = ST_WHT_LO;
        else                           state_next = ST_RND_A;
      end
      ST_WHT_LO: state_next = ST_WHT_HI;
      ST_WHT_HI: begin
        if (finish) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctrl        = '0;
    key_idx     = '0;
    ctrl.load   = start;
    ctrl.wht_hi = finish;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_RND_A: begin
        ctrl.rnd_a = 1'b1;
        // decryption walks the round keys from the top down
        if (dec) key_idx = KEY_IDX_W'(ROUNDS + 1) - KEY_IDX_W'(rnd);
        else     key_idx = KEY_IDX_W'(rnd);
      end
      ST_RND_B: ctrl.rnd_b = 1'b1;
      ST_WHT_LO: begin
        ctrl.wht_lo = 1'b1;
        key_idx     = dec ? KEY_IDX_W'(1) : KEY_IDX_W'(ROUNDS);
      end
      ST_WHT_HI: key_idx = dec ? KEY_IDX_W'(0) : KEY_IDX_W'(ROUNDS + 1);
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      dec       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        rnd <= '0;
        dec <= (in_mode == MODE_DEC);
      end else if (state == ST_RND_B) begin
        rnd <= rnd + RND_W'(1);
      end
      if (finish)         out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

[rtl/core/bfk_datapath.sv]
// round keys, block halves, round function and result register
// uses bfk_pkg and two bfk_sbox_ram banks (s0/s1 and s2/s3)
module bfk_datapath
  import bfk_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF,
  localparam int KEY_IDX_W = $clog2(ROUNDS + 2)
) (
  input  logic                 clk,
  input  dp_ctrl_t             ctrl,
  input  logic [KEY_IDX_W-1:0] key_idx,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_index,
  input  logic [WORD_W-1:0]    wr_word,
  input  logic [WORD_W-1:0]    block_lo,
  input  logic [WORD_W-1:0]    block_hi,
  output logic [WORD_W-1:0]    out_lo,
  output logic [WORD_W-1:0]    out_hi
);

  localparam int KEY_WORDS = ROUNDS + 2;

  logic [WORD_W-1:0]  round_keys [KEY_WORDS];
  logic [WORD_W-1:0]  x;
  logic [WORD_W-1:0]  y;
  logic [WORD_W-1:0]  z;
  logic [WORD_W-1:0]  key_word;
  logic [WORD_W-1:0]  z_next;
  logic [WORD_W-1:0]  f_val;
  logic [IDX_W-1:0]   s_off;
  logic               key_wr;
  logic               sbox_wr;
  logic [WORD_W-1:0]  rd_s0;
  logic [WORD_W-1:0]  rd_s1;
  logic [WORD_W-1:0]  rd_s2;
  logic [WORD_W-1:0]  rd_s3;

  assign key_word = round_keys[key_idx];
  assign z_next   = key_word ^ x;

  assign key_wr  = wr_en && (wr_index < IDX_W'(KEY_WORDS));
  assign s_off   = wr_index - IDX_W'(KEY_WORDS);
  assign sbox_wr = wr_en && (wr_index >= IDX_W'(KEY_WORDS)) &&
                   (wr_index < IDX_W'(KEY_WORDS + SBOX_WORDS));

  // bank a holds s0 then s1, bank b holds s2 then s3
  bfk_sbox_ram u_bank_a (
    .clk    (clk),
    .we     (sbox_wr && !s_off[BANK_AW]),
    .waddr  (s_off[BANK_AW-1:0]),
    .wdata  (wr_word),
    .raddr0 ({1'b0, z_next[4*BYTE_W-1:3*BYTE_W]}),
    .raddr1 ({1'b1, z_next[3*BYTE_W-1:2*BYTE_W]}),
    .rdata0 (rd_s0),
    .rdata1 (rd_s1)
  );

  bfk_sbox_ram u_bank_b (
    .clk    (clk),
    .we     (sbox_wr && s_off[BANK_AW]),
    .waddr  (s_off[BANK_AW-1:0]),
    .wdata  (wr_word),
    .raddr0 ({1'b0, z_next[2*BYTE_W-1:BYTE_W]}),
    .raddr1 ({1'b1, z_next[BYTE_W-1:0]}),
    .rdata0 (rd_s2),
    .rdata1 (rd_s3)
  );

  assign f_val = ((rd_s0 + rd_s1) ^ rd_s2) + rd_s3;

  always_ff @(posedge clk) begin
    if (key_wr) begin
      round_keys[wr_index[KEY_IDX_W-1:0]] <= wr_word;
    end
    if (ctrl.load) begin
      x <= block_hi;
      y <= block_lo;
    end else if (ctrl.rnd_a) begin
      z <= z_next;
    end else if (ctrl.rnd_b) begin
      x <= y ^ f_val;
      y <= z;
    end else if (ctrl.wht_lo) begin
      x <= x ^ key_word;
    end
    if (ctrl.wht_hi) begin
      out_lo <= x;
      out_hi <= y ^ key_word;
    end
  end

endmodule

[rtl/core/bfk_checker.sv]
// port-level checks for key1_blowfish_block_cipher, attached by bind
// uses bfk_pkg for the mode codes and port widths
module bfk_checker
  import bfk_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [MODE_W-1:0]    s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // result held while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a table write taken while no result is pending does not raise the result valid
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    s_xfer && (s_axis_tuser == MODE_WRITE) && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("table write gave a result");

  // a block needs its rounds: no result on the next cycle
  a_block_latency: assert property (@(posedge clk) disable iff (rst)
    s_xfer && ((s_axis_tuser == MODE_ENC) || (s_axis_tuser == MODE_DEC)) &&
    !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result too early");

  // input closed while a block is in the rounds
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_xfer && ((s_axis_tuser == MODE_ENC) || (s_axis_tuser == MODE_DEC))
    |=> !s_axis_tready)
    else $error("input open during rounds");

endmodule

bind key1_blowfish_block_cipher bfk_checker u_bfk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
